// ===== rtl/core/piwu_pkg.sv =====
// Package for the packed index word unpacker.
// Types, constants and helper functions shared by all rtl/core modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package piwu_pkg;

    localparam int WORD_W     = 64;
    localparam int INDEX_W    = 16;
    localparam int WIDTH_W    = 5;
    localparam int PERWORD_W  = 7;
    localparam int POS_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [CFG_DATA_W-1:0] PALETTE_RESET = 16'd2;
    localparam logic [POS_W-1:0]      ENTRIES_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_COUNT = 2'd0,
        CFG_MIN_FOUR_BITS = 2'd1,
        CFG_ENTRIES_TOTAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0]   width;
        logic [PERWORD_W-1:0] per_word;
        logic [INDEX_W-1:0]   mask;
        logic [INDEX_W-1:0]   limit;
        logic [INDEX_W-1:0]   clamp;
        logic [POS_W-1:0]     total;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_qout;

    function automatic logic [WIDTH_W-1:0] field_width(
        input logic [INDEX_W-1:0] pcount,
        input logic               min4
    );
        logic [INDEX_W-1:0] v;
        logic [WIDTH_W-1:0] w;
        v = pcount - 16'd1;
        w = '0;
        for (int i = 0; i < INDEX_W; i++) begin
            if (v[i]) begin
                w = WIDTH_W'(i + 1);
            end
        end
        if (min4 && w < 5'd4) begin
            w = 5'd4;
        end
        if (w == 5'd0) begin
            w = 5'd1;
        end
        return w;
    endfunction

    function automatic logic [PERWORD_W-1:0] fields_per_word(input logic [WIDTH_W-1:0] w);
        logic [PERWORD_W-1:0] n;
        case (w)
            5'd1:    n = 7'd64;
            5'd2:    n = 7'd32;
            5'd3:    n = 7'd21;
            5'd4:    n = 7'd16;
            5'd5:    n = 7'd12;
            5'd6:    n = 7'd10;
            5'd7:    n = 7'd9;
            5'd8:    n = 7'd8;
            5'd9:    n = 7'd7;
            5'd10:   n = 7'd6;
            5'd11:   n = 7'd5;
            5'd12:   n = 7'd5;
            5'd13:   n = 7'd4;
            5'd14:   n = 7'd4;
            5'd15:   n = 7'd4;
            5'd16:   n = 7'd4;
            default: n = 7'd4;
        endcase
        return n;
    endfunction

    function automatic logic [INDEX_W-1:0] field_mask(input logic [WIDTH_W-1:0] w);
        logic [INDEX_W:0] m;
        m = (17'd1 << w) - 17'd1;
        return m[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/piwu_cfg.sv =====
// Configuration registers and derived unpack settings.
// Depends on piwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module piwu_cfg #(
    parameter int MAX_ENTRIES = piwu_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [piwu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [piwu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output piwu_pkg::t_cfg                      o_cfg
);
    import piwu_pkg::*;

    logic [INDEX_W-1:0] r_palette_count;
    logic               r_min_four_bits;
    logic [POS_W-1:0]   r_entries_total;
    t_cfg               r_cfg;
    t_cfg               n_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= PALETTE_RESET;
            r_min_four_bits <= 1'b1;
            r_entries_total <= ENTRIES_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PALETTE_COUNT: r_palette_count <= i_cfg_data;
                CFG_MIN_FOUR_BITS: r_min_four_bits <= i_cfg_data[0];
                CFG_ENTRIES_TOTAL: r_entries_total <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cfg.width    = field_width(r_palette_count, r_min_four_bits);
        n_cfg.per_word = fields_per_word(n_cfg.width);
        n_cfg.mask     = field_mask(n_cfg.width);
        n_cfg.limit    = r_palette_count;
        n_cfg.clamp    = (r_palette_count == '0) ? '0 : r_palette_count - 16'd1;
        if (r_entries_total == '0) begin
            n_cfg.total = POS_W'(1);
        end else if (r_entries_total > POS_W'(MAX_ENTRIES)) begin
            n_cfg.total = POS_W'(MAX_ENTRIES);
        end else begin
            n_cfg.total = r_entries_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/piwu_front.sv =====
// Input side: accepts packed words into a short queue.
// Depends on piwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module piwu_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [piwu_pkg::WORD_W-1:0] i_packed_word,
    input  wire logic                        i_pop,
    output piwu_pkg::t_qout                  o_q
);
    import piwu_pkg::*;

    logic [WORD_W-1:0] r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_stall = (r_count == QCNT_W'(QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_packed_word;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.word  = r_mem[r_rptr];

endmodule

`default_nettype wire

// ===== rtl/core/piwu_back.sv =====
// Unpack engine: shifts fields out of one word, tracks array position,
// clamps and flags indices, and holds the output register.
// Depends on piwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module piwu_back #(
    parameter int MAX_ENTRIES = piwu_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire piwu_pkg::t_cfg                i_cfg,
    input  wire piwu_pkg::t_qout               i_q,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [piwu_pkg::INDEX_W-1:0]       o_palette_index,
    output logic                               o_out_of_range,
    output logic                               o_word_last,
    output logic                               o_array_last
);
    import piwu_pkg::*;

    logic                 r_busy;
    logic [WORD_W-1:0]    r_word;
    logic [PERWORD_W-2:0] r_k;
    logic [POS_W-1:0]     r_pos;
    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_index;
    logic                 r_oor;
    logic                 r_wlast;
    logic                 r_alast;

    logic                 step;
    logic [POS_W-1:0]     cur_pos;
    logic [INDEX_W-1:0]   raw;
    logic                 bad;
    logic                 last_arr;
    logic                 last_word;
    logic [POS_W-1:0]     n_pos;

    assign o_pop = !r_busy && i_q.valid;
    assign step  = r_busy && (!r_out_valid || !i_stall);

    always_comb begin
        cur_pos   = (r_pos >= i_cfg.total) ? '0 : r_pos;
        raw       = r_word[INDEX_W-1:0] & i_cfg.mask;
        bad       = (raw >= i_cfg.limit);
        last_arr  = ({1'b0, cur_pos} + 14'd1 == {1'b0, i_cfg.total});
        last_word = ({1'b0, r_k} + 7'd1 == i_cfg.per_word) || last_arr;
        n_pos     = last_arr ? '0 : cur_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (step && last_word) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_pos <= n_pos;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_q.word;
            r_k    <= '0;
        end else if (step) begin
            r_word <= r_word >> i_cfg.width;
            r_k    <= r_k + 1'b1;
        end
        if (step) begin
            r_index <= bad ? i_cfg.clamp : raw;
            r_oor   <= bad;
            r_wlast <= last_word;
            r_alast <= last_arr;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_palette_index = r_index;
    assign o_out_of_range  = r_oor;
    assign o_word_last     = r_wlast;
    assign o_array_last    = r_alast;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy)
        else $error("word taken while unpacking");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_k} < i_cfg.per_word))
        else $error("field count past word");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(MAX_ENTRIES))
        else $error("position beyond array limit");

    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last_arr) |=> (r_pos == '0) && !r_busy)
        else $error("no rewind after last array entry");

endmodule

`default_nettype wire

// ===== rtl/core/packed_index_word_unpacker.sv =====
// Top level of the packed index word unpacker.
// Instantiates piwu_cfg, piwu_front and piwu_back; depends on piwu_pkg.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_packed_word
//   output   out        o_valid / i_stall  o_palette_index, o_out_of_range,
//                                          o_word_last, o_array_last
//   config   in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One index leaves per cycle while a word is unpacking and i_stall is low;
// a word yields min(64/W, remaining) indices, 16 at the default 4-bit width,
// from the unpack engine's single field shifter, which loads a word when idle.
// Synchronous active-low reset clears the queue, position and valid state.
// A two-entry word queue lets input transfers continue while output stalls.
`timescale 1ns / 1ps
`default_nettype none

module packed_index_word_unpacker #(
    parameter int MAX_ENTRIES = piwu_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [piwu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [piwu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [piwu_pkg::WORD_W-1:0]     i_packed_word,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [piwu_pkg::INDEX_W-1:0]         o_palette_index,
    output logic                                 o_out_of_range,
    output logic                                 o_word_last,
    output logic                                 o_array_last
);
    import piwu_pkg::*;

    t_cfg  cfg;
    t_qout q;
    logic  pop;

    piwu_cfg #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    piwu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_packed_word (i_packed_word),
        .i_pop         (pop),
        .o_q           (q)
    );

    piwu_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q             (q),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_palette_index (o_palette_index),
        .o_out_of_range  (o_out_of_range),
        .o_word_last     (o_word_last),
        .o_array_last    (o_array_last)
    );

endmodule

`default_nettype wire
